### rtl/sha_pkg.sv
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    localparam logic [255:0] HASH_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

### rtl/sha256_byte_stream_hasher_core.sv
// SHA-256 over a byte stream.
// Input channel s_*: one request per byte; byte_valid marks a message byte,
// message_end closes the message (a request may carry a bare end mark).
// Output channel m_*: eight digest words, most significant first, last_word
// high on the eighth.
// A byte that does not fill the block leaves s_ready high for the next byte.
// A byte that fills the 64-byte block starts the compressor: a load step,
// the rounds and a finish step, all with s_ready low; no new byte is taken
// until the block is hashed. The single round unit in sha_compress sets the pace.
// On an end request the block pads one byte a cycle (the pad, zeros, the
// 64-bit bit count), compressing once, or twice when the pad byte lands in
// the last eight bytes of the block; a byte that fills the block adds one
// more compression before the padding.
// The eight words are shown one per handshake and hold under m_ready low.
// The input side stays stalled until the last word is taken.
// Reset (aresetn low, synchronous) loads the initial hash, clears the fill
// count and bit count and drops m_valid; s_ready is high right after reset.
module sha256_byte_stream_hasher_core
    import sha_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sha_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sha_out_t m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_PAD  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    logic [2:0]   state_reg;
    logic [511:0] blk_reg;     // block bytes, first byte at the top
    logic [5:0]   fill_reg;
    logic [63:0]  len_reg;
    logic [255:0] hash_reg;
    logic         fin_reg;     // message end seen; cleared after the last digest word
    logic         pad_first_reg;
    logic         pad_extra_reg; // pad byte went in past byte 55, one more block
    logic [2:0]   widx_reg;
    logic         start_reg;
    logic         comp_done;
    logic [255:0] comp_hash;
    logic         s_acc;
    logic [7:0]   pad_byte;
    logic [2:0]   len_sel;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;

    sha_compress u_comp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .block    (blk_reg),
        .hash_in  (hash_reg),
        .done     (comp_done),
        .hash_out (comp_hash)
    );

    // padding byte for the current fill position
    assign len_sel = fill_reg[2:0];
    always_comb begin
        if (pad_first_reg) begin
            pad_byte = PAD_BYTE;
        end else if (fill_reg >= 6'd56 && !pad_extra_reg) begin
            pad_byte = len_reg[63 - {len_sel, 3'b000} -: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // block shift register
    always_ff @(posedge aclk) begin
        if (s_acc && s_data.byte_valid) begin
            blk_reg <= {blk_reg[503:0], s_data.data_byte};
        end else if (state_reg == ST_PAD) begin
            blk_reg <= {blk_reg[503:0], pad_byte};
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            hash_reg      <= HASH_INIT;
            fin_reg       <= 1'b0;
            pad_first_reg <= 1'b0;
            pad_extra_reg <= 1'b0;
            widx_reg      <= '0;
            start_reg     <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (s_data.byte_valid) begin
                            len_reg  <= len_reg + 64'd8;
                            fill_reg <= fill_reg + 6'd1;
                        end
                        if (s_data.message_end) begin
                            fin_reg       <= 1'b1;
                            pad_first_reg <= 1'b1;
                        end
                        if (s_data.byte_valid && fill_reg == 6'd63) begin
                            state_reg <= ST_COMP;
                            start_reg <= 1'b1;
                        end else if (s_data.message_end) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    pad_first_reg <= 1'b0;
                    if (pad_first_reg && fill_reg >= 6'd56) begin
                        pad_extra_reg <= 1'b1;
                    end
                    fill_reg      <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63) begin
                        state_reg <= ST_COMP;
                        start_reg <= 1'b1;
                    end
                end
                ST_COMP: begin
                    if (comp_done) begin
                        hash_reg <= comp_hash;
                        if (!fin_reg) begin
                            state_reg <= ST_IDLE;
                        end else if (pad_first_reg) begin
                            state_reg <= ST_PAD;
                        end else if (pad_extra_reg) begin
                            pad_extra_reg <= 1'b0;
                            state_reg     <= ST_PAD;
                        end else begin
                            state_reg <= ST_OUT;
                            widx_reg  <= '0;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7) begin
                            state_reg <= ST_IDLE;
                            hash_reg  <= HASH_INIT;
                            len_reg   <= '0;
                            fill_reg  <= '0;
                            fin_reg   <= 1'b0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid            = (state_reg == ST_OUT);
    assign m_data.digest_word = hash_reg[255 - {widx_reg, 5'b00000} -: 32];
    assign m_data.word_index  = widx_reg;
    assign m_data.last_word   = (widx_reg == 3'd7);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(widx_reg))
        else $error("digest word lost under stall");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("input accepted while busy");
    a_pad_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |-> fin_reg && fill_reg == 6'd0)
        else $error("digest shown before padding finished");

endmodule

### rtl/sha_compress.sv
// One SHA-256 round per cycle over a 16-word sliding message schedule.
module sha_compress
    import sha_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [511:0] block,
    input  logic [255:0] hash_in,
    output logic         done,
    output logic [255:0] hash_out
);

    logic [511:0] w_reg;
    logic [255:0] v_reg;
    logic [5:0]   round_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [31:0] a, b, c, d, e, f, g, h, w0, w1, w9, w14, w_new;
    logic [31:0] s0, s1, big0, big1, ch, maj, t1, t2;

    assign {a, b, c, d, e, f, g, h} = v_reg;
    assign w0  = w_reg[511:480];
    assign w1  = w_reg[479:448];
    assign w9  = w_reg[223:192];
    assign w14 = w_reg[63:32];

    // schedule word sixteen ahead
    always_comb begin
        s0    = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
        s1    = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
        w_new = w0 + s0 + w9 + s1;
    end

    // round datapath
    always_comb begin
        big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
        ch   = (e & f) ^ (~e & g);
        t1   = h + big1 + ch + round_k(round_reg) + w0;
        big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
        maj  = (a & b) ^ (a & c) ^ (b & c);
        t2   = big0 + maj;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end else if (busy_reg) begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            w_reg <= block;
            v_reg <= hash_in;
        end else if (busy_reg) begin
            w_reg <= {w_reg[479:0], w_new};
            v_reg <= {t1 + t2, a, b, c, d + t1, e, f, g};
        end
    end

    // final feed-forward add
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            hash_out[i*32 +: 32] = hash_in[i*32 +: 32] + v_reg[i*32 +: 32];
        end
    end

    assign done = done_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a running compression");
    a_round_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && !start |=> round_reg == $past(round_reg))
        else $error("round counter moved while idle");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("start while compressing");

endmodule
